### src/bwd_pkg.sv
`default_nettype none

package bwd_pkg;

  // register indexes, taken from paddr[4:2]
  localparam logic [2:0] REG_USE_PRIOR   = 3'd0;
  localparam logic [2:0] REG_TOP_FIELD   = 3'd1;
  localparam logic [2:0] REG_WIDE        = 3'd2;
  localparam logic [2:0] REG_FRAME_WIDTH = 3'd3;
  localparam logic [2:0] REG_FRAME_LINES = 3'd4;

  localparam logic [11:0] FRAME_WIDTH_RST = 12'd720;
  localparam logic [12:0] FRAME_LINES_RST = 13'd480;

  typedef struct packed {
    logic        use_prior_frame;
    logic        top_field;
    logic        wide_channels;
    logic [11:0] frame_width;
    logic [12:0] frame_lines;
  } cfg_t;

  // position of the word being accepted
  typedef struct packed {
    logic [11:0] line;
    logic [10:0] col;
    logic        eof;
    logic        rep;    // this line is replaced
    logic        prev;   // line above is replaced
  } pos_t;

  // item handed to the output stage
  typedef struct packed {
    logic [63:0] pix;
    logic [11:0] line;
    logic [10:0] col;
    logic        eof;
    logic        pair;   // emit interpolated pixel for line above first
  } item_t;

  typedef struct packed {
    logic s2_valid;
    logic pair_pending;
  } emit_stat_t;

endpackage

`default_nettype wire

### src/bwd_regs.sv
`default_nettype none

module bwd_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [4:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  output logic      [31:0]   cfg_prdata,
  output logic               cfg_pready,
  output bwd_pkg::cfg_t      cfg
);

  bwd_pkg::cfg_t cfg_r;
  bwd_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [2:0]    idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = cfg_paddr[4:2];
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        bwd_pkg::REG_USE_PRIOR:   cfg_nxt.use_prior_frame = cfg_pwdata[0];
        bwd_pkg::REG_TOP_FIELD:   cfg_nxt.top_field       = cfg_pwdata[0];
        bwd_pkg::REG_WIDE:        cfg_nxt.wide_channels   = cfg_pwdata[0];
        bwd_pkg::REG_FRAME_WIDTH: cfg_nxt.frame_width     = cfg_pwdata[11:0];
        bwd_pkg::REG_FRAME_LINES: cfg_nxt.frame_lines     = cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bwd_pkg::REG_USE_PRIOR:   cfg_prdata = {31'd0, cfg_r.use_prior_frame};
      bwd_pkg::REG_TOP_FIELD:   cfg_prdata = {31'd0, cfg_r.top_field};
      bwd_pkg::REG_WIDE:        cfg_prdata = {31'd0, cfg_r.wide_channels};
      bwd_pkg::REG_FRAME_WIDTH: cfg_prdata = {20'd0, cfg_r.frame_width};
      bwd_pkg::REG_FRAME_LINES: cfg_prdata = {19'd0, cfg_r.frame_lines};
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.use_prior_frame <= 1'b0;
      cfg_r.top_field       <= 1'b1;
      cfg_r.wide_channels   <= 1'b0;
      cfg_r.frame_width     <= bwd_pkg::FRAME_WIDTH_RST;
      cfg_r.frame_lines     <= bwd_pkg::FRAME_LINES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### src/bwd_position.sv
`default_nettype none

module bwd_position #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_LINES = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bwd_pkg::cfg_t                cfg,
  input  wire logic                         adv,
  output bwd_pkg::pos_t                     pos,
  output logic [$clog2(MAX_WIDTH)-1:0]      col_idx
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = $clog2(MAX_LINES);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int EL = $clog2(MAX_LINES + 1);

  logic [CW-1:0] col_cnt_r;
  logic [LW-1:0] line_cnt_r;
  logic [CW-1:0] col_cnt_nxt;
  logic [LW-1:0] line_cnt_nxt;

  logic [EW-1:0] eff_w;
  logic [EL-1:0] eff_l;
  logic [CW-1:0] col_c;
  logic [LW-1:0] line_c;
  logic [EW-1:0] col_inc;
  logic [EL-1:0] line_inc;
  logic [1:0]    start;

  function automatic logic is_rep(input logic [EL-1:0] ln, input logic [1:0] st,
                                  input logic [EL-1:0] lim);
    return (ln >= EL'(st)) && ((ln + EL'(1)) < lim) && (ln[0] == st[0]);
  endfunction

  // clamp frame size to 1..MAX_WIDTH and 2..MAX_LINES
  always_comb begin
    if (cfg.frame_width == 12'd0) begin
      eff_w = EW'(1);
    end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(cfg.frame_width);
    end
    if (32'(cfg.frame_lines) < 32'd2) begin
      eff_l = EL'(2);
    end else if (32'(cfg.frame_lines) > 32'(MAX_LINES)) begin
      eff_l = EL'(MAX_LINES);
    end else begin
      eff_l = EL'(cfg.frame_lines);
    end
  end

  // a position past a shrunk frame wraps to zero
  assign col_c    = (EW'(col_cnt_r) >= eff_w) ? '0 : col_cnt_r;
  assign line_c   = (EL'(line_cnt_r) >= eff_l) ? '0 : line_cnt_r;
  assign col_inc  = EW'(col_c) + EW'(1);
  assign line_inc = EL'(line_c) + EL'(1);

  assign start = cfg.top_field ? 2'd1 : (cfg.use_prior_frame ? 2'd0 : 2'd2);

  always_comb begin
    pos.line = 12'(line_c);
    pos.col  = 11'(col_c);
    pos.eof  = (line_inc == eff_l) && (col_inc == eff_w);
    pos.rep  = is_rep(EL'(line_c), start, eff_l);
    pos.prev = (line_c != '0) && is_rep(EL'(line_c) - EL'(1), start, eff_l);
  end

  assign col_idx = col_c;

  always_comb begin
    col_cnt_nxt  = col_cnt_r;
    line_cnt_nxt = line_cnt_r;
    if (adv) begin
      if (col_inc >= eff_w) begin
        col_cnt_nxt  = '0;
        line_cnt_nxt = (line_inc >= eff_l) ? '0 : LW'(line_inc);
      end else begin
        col_cnt_nxt  = CW'(col_inc);
        line_cnt_nxt = line_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      line_cnt_r <= '0;
    end else begin
      col_cnt_r  <= col_cnt_nxt;
      line_cnt_r <= line_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### src/bwd_line_store.sv
`default_nettype none

module bwd_line_store #(
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [63:0]              wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [63:0]              rdata
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata_r;

  assign rdata = rdata_r;

  // read returns the old entry on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

### src/bwd_emit.sv
`default_nettype none

module bwd_emit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wide,
  input  wire logic           ld_valid,
  input  wire bwd_pkg::item_t ld_item,
  input  wire logic [63:0]    above_pix,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [87:0]         out_tdata,
  output logic                out_tlast,
  output bwd_pkg::emit_stat_t stat
);

  logic            s2_v_r, s2_v_nxt;
  logic            first_r, first_nxt;
  bwd_pkg::item_t  s2_item_r;
  logic            out_v_r, out_v_nxt;
  logic [63:0]     o_pix_r, o_pix_nxt;
  logic [11:0]     o_line_r, o_line_nxt;
  logic [10:0]     o_col_r, o_col_nxt;
  logic            o_last_r, o_last_nxt;
  logic            out_free;
  logic            take;
  logic            s2_done;

  function automatic logic [63:0] avg_px(input logic [63:0] a, input logic [63:0] b,
                                         input logic w16);
    logic [63:0] r;
    logic [16:0] s16;
    logic [8:0]  s8;
    r = '0;
    if (w16) begin
      for (int i = 0; i < 4; i++) begin
        s16 = {1'b0, a[16*i +: 16]} + {1'b0, b[16*i +: 16]};
        r[16*i +: 16] = s16[16:1];
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        s8 = {1'b0, a[8*i +: 8]} + {1'b0, b[8*i +: 8]};
        r[8*i +: 8] = s8[8:1];
      end
      r[31:24] = 8'hFF;
    end
    return r;
  endfunction

  assign out_free  = !out_v_r || out_tready;
  assign take      = s2_v_r && out_free;
  assign s2_done   = take && !first_r;
  assign in_tready = !s2_v_r || s2_done;

  always_comb begin
    s2_v_nxt  = s2_v_r;
    first_nxt = first_r;
    if (ld_valid) begin
      s2_v_nxt  = 1'b1;
      first_nxt = ld_item.pair;
    end else if (s2_done) begin
      s2_v_nxt = 1'b0;
    end else if (take) begin
      first_nxt = 1'b0;
    end
    out_v_nxt = take ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  // interpolated word for the line above goes out ahead of the word itself
  always_comb begin
    o_pix_nxt  = o_pix_r;
    o_line_nxt = o_line_r;
    o_col_nxt  = o_col_r;
    o_last_nxt = o_last_r;
    if (take) begin
      o_col_nxt = s2_item_r.col;
      if (first_r) begin
        o_pix_nxt  = avg_px(above_pix, s2_item_r.pix, wide);
        o_line_nxt = s2_item_r.line - 12'd1;
        o_last_nxt = 1'b0;
      end else begin
        o_pix_nxt  = s2_item_r.pix;
        o_line_nxt = s2_item_r.line;
        o_last_nxt = s2_item_r.eof;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      first_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s2_v_r  <= s2_v_nxt;
      first_r <= first_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_valid) begin
      s2_item_r <= ld_item;
    end
    o_pix_r  <= o_pix_nxt;
    o_line_r <= o_line_nxt;
    o_col_r  <= o_col_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_tvalid        = out_v_r;
  assign out_tdata         = {1'b0, o_col_r, o_line_r, o_pix_r};
  assign out_tlast         = o_last_r;
  assign stat.s2_valid     = s2_v_r;
  assign stat.pair_pending = first_r;

endmodule

`default_nettype wire

### src/bob_weave_deinterlacer_top.sv
// Path: an accepted word is registered in s2_item_r, then in the output registers that
// drive out_tdata; the second word of an interpolated pair follows the first out of them.
// Throughput: one input word per cycle while out_tready is high, bounded by one output word
// per cycle on the result port, so a bob word completing a replaced line holds in_tready low.
// Reset (synchronous, active low) clears position counters, pipeline valids and
// config registers to defaults; line store contents stay undefined (no clear pass).
`default_nettype none

module bob_weave_deinterlacer_top #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_LINES = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [127:0]  in_tdata,    // current_pixel, prior_pixel
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic      [87:0]   out_tdata,   // out_pixel, out_line, out_column, zero pad
  output logic               out_tlast,   // end_of_frame
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [4:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  output logic      [31:0]   cfg_prdata,
  output logic               cfg_pready
);

  localparam int CW = $clog2(MAX_WIDTH);

  bwd_pkg::cfg_t       cfg;
  bwd_pkg::pos_t       pos;
  bwd_pkg::item_t      item;
  bwd_pkg::emit_stat_t stat;
  logic [CW-1:0]       col_idx;
  logic                in_accept;
  logic                item_has;
  logic                st_we;
  logic [63:0]         cur_pix;
  logic [63:0]         pri_pix;
  logic [63:0]         above_pix;

  bwd_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign in_accept = in_tvalid & in_tready;

  bwd_position #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_LINES (MAX_LINES)
  ) u_position (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .adv     (in_accept),
    .pos     (pos),
    .col_idx (col_idx)
  );

  // 8-bit mode keeps only the low 32 bits
  assign cur_pix = cfg.wide_channels ? in_tdata[63:0]   : {32'd0, in_tdata[31:0]};
  assign pri_pix = cfg.wide_channels ? in_tdata[127:64] : {32'd0, in_tdata[95:64]};

  always_comb begin
    item.pix  = (cfg.use_prior_frame && pos.rep) ? pri_pix : cur_pix;
    item.line = pos.line;
    item.col  = pos.col;
    item.eof  = pos.eof;
    item.pair = !cfg.use_prior_frame && pos.prev;
  end

  assign item_has = cfg.use_prior_frame || !pos.rep;
  assign st_we    = in_accept && !cfg.use_prior_frame && !pos.rep;

  bwd_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (col_idx),
    .wdata (cur_pix),
    .re    (in_accept),
    .raddr (col_idx),
    .rdata (above_pix)
  );

  bwd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .wide       (cfg.wide_channels),
    .ld_valid   (in_accept && item_has),
    .ld_item    (item),
    .above_pix  (above_pix),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .stat       (stat)
  );

  a_load_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && item_has) |=> stat.s2_valid)
    else $error("accepted word with results did not reach the output stage");

  a_weave_no_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && cfg.use_prior_frame) |=> !stat.pair_pending)
    else $error("weave mode produced an interpolated pair");

  a_bob_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !cfg.use_prior_frame && pos.rep) |=> !stat.s2_valid)
    else $error("replaced bob word left an item in the output stage");

endmodule

`default_nettype wire
